@@ hdl/cct_pkg.sv @@
// ----------------------------------------------------------------------------
// cct_pkg
// shared types and constants for the cluster chain table engine
// ----------------------------------------------------------------------------
`default_nettype none

package cct_pkg;

  localparam int MAX_CLUSTERS = 65536;
  localparam int ADDR_W       = $clog2(MAX_CLUSTERS);
  localparam int LINK_W       = 28;
  localparam int CNT_W        = 17;

  localparam logic [LINK_W-1:0] LINK_MASK = 28'hFFF_FFFF;
  localparam logic [LINK_W-1:0] EOC_LOW   = 28'hFFF_FFF8;

  // command codes
  localparam logic [2:0] CMD_READ  = 3'd0;
  localparam logic [2:0] CMD_WRITE = 3'd1;
  localparam logic [2:0] CMD_ALLOC = 3'd2;
  localparam logic [2:0] CMD_FREE  = 3'd3;
  localparam logic [2:0] CMD_WALK  = 3'd4;
  localparam logic [2:0] CMD_COUNT = 3'd5;

  // error codes
  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_RANGE = 2'd1;
  localparam logic [1:0] ERR_CYCLE = 2'd2;

  typedef struct packed {
    logic [2:0]        command;
    logic [LINK_W-1:0] cluster;
    logic [31:0]       entry_value;
    logic [LINK_W-1:0] step_limit;
  } req_t;

  typedef struct packed {
    logic [LINK_W-1:0] cluster_result;
    logic [CNT_W-1:0]  count_result;
    logic [1:0]        error_code;
  } rsp_t;

  // flags from the shared link compare unit
  typedef struct packed {
    logic below_eff;
    logic is_zero;
    logic is_eoc;
  } link_flags_t;

endpackage

`default_nettype wire

@@ hdl/cluster_chain_table_engine.sv @@
// ----------------------------------------------------------------------------
// cluster_chain_table_engine
// next-fit cluster allocator and chain walker over a 28-bit link table
// ----------------------------------------------------------------------------
// operation: allocate scans entries onward from the hint, free and walk step
//   link by link, count free (uncached) scans the whole table
// throughput: one request at a time; the single table port and the shared
//   link compare unit are stepped by the sequencer
// reset: a clearing pass zeroes the table, no request is taken
//   meanwhile; configuration writes are taken at any time
`default_nettype none

module cluster_chain_table_engine
  import cct_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_stall,
  input  wire req_t             req,
  output logic                  rsp_valid,
  input  wire logic             rsp_stall,
  output rsp_t                  rsp,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CNT_W-1:0] cfg_data
);

  logic              tbl_we;
  logic [ADDR_W-1:0] tbl_addr;
  logic [LINK_W-1:0] tbl_wdata;
  logic [LINK_W-1:0] tbl_rdata;
  logic [LINK_W-1:0] unit_operand;
  logic [CNT_W-1:0]  eff;
  link_flags_t       flags;

  // sequencer
  cct_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req          (req),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .rsp          (rsp),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .tbl_we       (tbl_we),
    .tbl_addr     (tbl_addr),
    .tbl_wdata    (tbl_wdata),
    .tbl_rdata    (tbl_rdata),
    .unit_operand (unit_operand),
    .eff          (eff),
    .flags        (flags)
  );

  // link table
  cct_table u_table (
    .clk   (clk),
    .we    (tbl_we),
    .addr  (tbl_addr),
    .wdata (tbl_wdata),
    .rdata (tbl_rdata)
  );

  // shared compare unit
  cct_link_unit u_link (
    .operand (unit_operand),
    .eff     (eff),
    .flags   (flags)
  );

endmodule

`default_nettype wire

@@ hdl/cct_table.sv @@
// ----------------------------------------------------------------------------
// cct_table
// single port link table, registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module cct_table
  import cct_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] addr,
  input  wire logic [LINK_W-1:0] wdata,
  output logic      [LINK_W-1:0] rdata
);

  logic [LINK_W-1:0] mem [MAX_CLUSTERS];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

@@ hdl/cct_link_unit.sv @@
// ----------------------------------------------------------------------------
// cct_link_unit
// shared compare unit: range, zero and end-of-chain checks on one link
// ----------------------------------------------------------------------------
`default_nettype none

module cct_link_unit
  import cct_pkg::*;
(
  input  wire logic [LINK_W-1:0] operand,
  input  wire logic [CNT_W-1:0]  eff,
  output link_flags_t            flags
);

  // all three checks on the selected operand
  always_comb begin
    flags.below_eff = operand < {{(LINK_W-CNT_W){1'b0}}, eff};
    flags.is_zero   = operand == '0;
    flags.is_eoc    = (operand == '0) || (operand >= EOC_LOW);
  end

endmodule

`default_nettype wire

@@ hdl/cct_ctrl.sv @@
// ----------------------------------------------------------------------------
// cct_ctrl
// command sequencer: drives the table port and the shared link unit
// ----------------------------------------------------------------------------
`default_nettype none

module cct_ctrl
  import cct_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_stall,
  input  wire req_t              req,
  output logic                   rsp_valid,
  input  wire logic              rsp_stall,
  output rsp_t                   rsp,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CNT_W-1:0]  cfg_data,
  output logic                   tbl_we,
  output logic      [ADDR_W-1:0] tbl_addr,
  output logic      [LINK_W-1:0] tbl_wdata,
  input  wire logic [LINK_W-1:0] tbl_rdata,
  output logic      [LINK_W-1:0] unit_operand,
  output logic      [CNT_W-1:0]  eff,
  input  wire link_flags_t       flags
);

  typedef enum logic [12:0] {
    S_CLEAR     = 13'b0000000000001,
    S_IDLE      = 13'b0000000000010,
    S_DECODE    = 13'b0000000000100,
    S_READ_RD   = 13'b0000000001000,
    S_ALLOC_CHK = 13'b0000000010000,
    S_ALLOC_RD  = 13'b0000000100000,
    S_FREE_CHK  = 13'b0000001000000,
    S_FREE_RD   = 13'b0000010000000,
    S_WALK_CHK  = 13'b0000100000000,
    S_WALK_RD   = 13'b0001000000000,
    S_COUNT_RD  = 13'b0010000000000,
    S_COUNT_FIN = 13'b0100000000000,
    S_FINISH    = 13'b1000000000000
  } state_t;

  state_t            state, state_next;
  req_t              cmd_req;
  logic [CNT_W-1:0]  num_clusters;
  logic [CNT_W-1:0]  hint, hint_next;
  logic [CNT_W-1:0]  free_count, free_count_next;
  logic [LINK_W-1:0] cur, cur_next;
  logic [LINK_W-1:0] endc, endc_next;
  logic [CNT_W-1:0]  low, low_next;
  logic [CNT_W-1:0]  len, len_next;
  logic [ADDR_W-1:0] idx, idx_next;
  logic              pend, pend_next;
  logic [CNT_W-1:0]  zcnt, zcnt_next;
  logic [LINK_W-1:0] res, res_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic [1:0]        err, err_next;
  logic              limited;
  logic              len_ge_eff;
  logic              len_lt_lim;
  logic [CNT_W:0]    free_sum;
  logic [CNT_W-1:0]  zcnt_inc;

  // usable cluster count
  assign eff = (num_clusters > CNT_W'(MAX_CLUSTERS)) ? CNT_W'(MAX_CLUSTERS) : num_clusters;

  assign cfg_ready  = 1'b1;
  assign req_stall  = (state != S_IDLE);
  assign limited    = cmd_req.step_limit != '0;
  assign len_ge_eff = len >= eff;
  assign len_lt_lim = {{(LINK_W-CNT_W){1'b0}}, len} < cmd_req.step_limit;
  // free count plus the chain length including the entry freed now
  assign free_sum   = {1'b0, free_count} + {1'b0, len} + 1'b1;
  assign zcnt_inc   = zcnt + CNT_W'(pend && (tbl_rdata == '0));

  // operand select for the shared link unit
  always_comb begin
    if (state == S_ALLOC_RD || state == S_FREE_RD || state == S_WALK_RD) begin
      unit_operand = tbl_rdata;
    end else begin
      unit_operand = cur;
    end
  end

  // table port
  always_comb begin
    tbl_we    = 1'b0;
    tbl_wdata = '0;
    tbl_addr  = cur[ADDR_W-1:0];
    if (state == S_CLEAR || state == S_COUNT_RD) begin
      tbl_addr = idx;
    end
    if (state == S_CLEAR) begin
      tbl_we = 1'b1;
    end else if (state == S_DECODE && cmd_req.command == CMD_WRITE &&
                 flags.below_eff && !flags.is_zero) begin
      tbl_we    = 1'b1;
      tbl_wdata = cmd_req.entry_value[LINK_W-1:0];
    end else if (state == S_ALLOC_RD && flags.is_zero) begin
      tbl_we    = 1'b1;
      tbl_wdata = LINK_MASK;
    end else if (state == S_FREE_RD) begin
      tbl_we = 1'b1;
    end
  end

  // sequencer
  always_comb begin
    state_next      = state;
    hint_next       = hint;
    free_count_next = free_count;
    cur_next        = cur;
    endc_next       = endc;
    low_next        = low;
    len_next        = len;
    idx_next        = idx;
    pend_next       = 1'b0;
    zcnt_next       = zcnt;
    res_next        = res;
    cnt_next        = cnt;
    err_next        = err;
    unique case (state)
      S_CLEAR: begin
        idx_next = idx + 1'b1;
        if (idx == '1) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cur_next   = req.cluster;
          res_next   = '0;
          cnt_next   = '0;
          err_next   = ERR_OK;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_FINISH;
        case (cmd_req.command)
          CMD_READ: begin
            if (flags.below_eff) state_next = S_READ_RD;
            else err_next = ERR_RANGE;
          end
          CMD_WRITE: begin
            if (!flags.below_eff || flags.is_zero) err_next = ERR_RANGE;
          end
          CMD_ALLOC: begin
            cur_next   = {{(LINK_W-CNT_W){1'b0}}, hint};
            state_next = S_ALLOC_CHK;
          end
          CMD_FREE: begin
            low_next   = cur[CNT_W-1:0];
            len_next   = '0;
            state_next = S_FREE_CHK;
          end
          CMD_WALK: begin
            endc_next  = cur;
            len_next   = '0;
            state_next = S_WALK_CHK;
          end
          CMD_COUNT: begin
            if (free_count == '0) begin
              idx_next   = '0;
              zcnt_next  = '0;
              state_next = S_COUNT_RD;
            end else begin
              cnt_next = free_count;
            end
          end
          default: err_next = ERR_RANGE;
        endcase
      end
      S_READ_RD: begin
        res_next   = tbl_rdata;
        state_next = S_FINISH;
      end
      S_ALLOC_CHK: begin
        if (flags.below_eff) begin
          state_next = S_ALLOC_RD;
        end else begin
          err_next   = ERR_RANGE;
          state_next = S_FINISH;
        end
      end
      S_ALLOC_RD: begin
        if (flags.is_zero) begin
          hint_next = cur[CNT_W-1:0];
          if (free_count != '0) free_count_next = free_count - 1'b1;
          res_next   = cur;
          state_next = S_FINISH;
        end else begin
          cur_next   = cur + 1'b1;
          state_next = S_ALLOC_CHK;
        end
      end
      S_FREE_CHK: begin
        if (!flags.below_eff || flags.is_zero) begin
          err_next   = ERR_RANGE;
          state_next = S_FINISH;
        end else begin
          state_next = S_FREE_RD;
        end
      end
      S_FREE_RD: begin
        if (cur[CNT_W-1:0] < low) low_next = cur[CNT_W-1:0];
        len_next = len + 1'b1;
        cur_next = tbl_rdata;
        if (flags.is_eoc) begin
          if (hint > low_next) hint_next = low_next;
          free_count_next = free_sum[CNT_W] ? '1 : free_sum[CNT_W-1:0];
          cnt_next   = len_next;
          state_next = S_FINISH;
        end else begin
          state_next = S_FREE_CHK;
        end
      end
      S_WALK_CHK: begin
        if (!limited && flags.is_eoc) begin
          res_next   = endc;
          cnt_next   = len;
          state_next = S_FINISH;
        end else if (limited && !len_lt_lim) begin
          res_next   = cur;
          cnt_next   = len;
          state_next = S_FINISH;
        end else if (len_ge_eff) begin
          err_next   = ERR_CYCLE;
          state_next = S_FINISH;
        end else if (!flags.below_eff) begin
          err_next   = ERR_RANGE;
          state_next = S_FINISH;
        end else begin
          endc_next  = cur;
          state_next = S_WALK_RD;
        end
      end
      S_WALK_RD: begin
        len_next = len + 1'b1;
        if (limited && flags.is_eoc) begin
          res_next   = cur;
          cnt_next   = len_next;
          state_next = S_FINISH;
        end else begin
          cur_next   = tbl_rdata;
          state_next = S_WALK_CHK;
        end
      end
      S_COUNT_RD: begin
        zcnt_next = zcnt_inc;
        pend_next = 1'b1;
        idx_next  = idx + 1'b1;
        if (idx == '1) state_next = S_COUNT_FIN;
      end
      S_COUNT_FIN: begin
        free_count_next = (zcnt_inc > num_clusters) ? num_clusters : zcnt_inc;
        cnt_next        = free_count_next;
        state_next      = S_FINISH;
      end
      S_FINISH: begin
        if (!rsp_valid || !rsp_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      idx          <= '0;
      pend         <= 1'b0;
      hint         <= CNT_W'(2);
      free_count   <= '0;
      num_clusters <= CNT_W'(MAX_CLUSTERS);
      rsp_valid    <= 1'b0;
    end else begin
      state      <= state_next;
      idx        <= idx_next;
      pend       <= pend_next;
      hint       <= hint_next;
      free_count <= free_count_next;
      if (cfg_valid && cfg_ready) num_clusters <= cfg_data;
      if (state == S_FINISH && (!rsp_valid || !rsp_stall)) rsp_valid <= 1'b1;
      else if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
    end
  end

  // working registers and response payload
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) cmd_req <= req;
    cur  <= cur_next;
    endc <= endc_next;
    low  <= low_next;
    len  <= len_next;
    zcnt <= zcnt_next;
    res  <= res_next;
    cnt  <= cnt_next;
    err  <= err_next;
    if (state == S_FINISH && (!rsp_valid || !rsp_stall)) begin
      rsp.cluster_result <= (err != ERR_OK) ? '0 : res;
      rsp.count_result   <= (err != ERR_OK) ? '0 : cnt;
      rsp.error_code     <= err;
    end
  end

endmodule

`default_nettype wire

@@ test/cluster_chain_table_engine_test.sv @@
// ----------------------------------------------------------------------------
// cluster_chain_table_engine_test
// self-checking bench: a behavioral table model predicts every response while
// directed and random command streams run under several cluster counts
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module cluster_chain_table_engine_test;
  import cct_pkg::*;

  localparam int WATCHDOG_LIMIT = 600000;
  localparam int MAX_REPORTS    = 10;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             req_valid = 1'b0;
  logic             req_stall;
  req_t             req = '0;
  logic             rsp_valid;
  logic             rsp_stall = 1'b0;
  rsp_t             rsp;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data = '0;

  // table model state
  logic [LINK_W-1:0] link_table [MAX_CLUSTERS];
  logic [CNT_W-1:0]  hint_model;
  logic [CNT_W-1:0]  free_cache;
  logic [CNT_W-1:0]  cluster_cfg;

  rsp_t pending_rsp [$];
  int   mismatches   = 0;
  int   requests_sent = 0;
  int   responses_seen = 0;
  int   idle_cycles  = 0;
  int   full_scans_left = 6;
  int   burst_left   = 0;
  int   cmd_hits [8];

  cluster_chain_table_engine uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // link is end of chain when zero or in the reserved top range
  function automatic bit link_ends(logic [LINK_W-1:0] v);
    return v == '0 || v >= EOC_LOW;
  endfunction

  function automatic int usable_count();
    return (int'(cluster_cfg) < MAX_CLUSTERS) ? int'(cluster_cfg) : MAX_CLUSTERS;
  endfunction

  // apply one command to the table model and return its response
  function automatic rsp_t table_apply(req_t r);
    rsp_t              o;
    int                eff;
    int unsigned       len;
    int unsigned       low;
    int unsigned       sum;
    int unsigned       zeros;
    logic [LINK_W-1:0] cur;
    logic [LINK_W-1:0] nxt;
    logic [LINK_W-1:0] last;
    bit                done;
    o = '0;
    eff = usable_count();
    len = 0;
    done = 0;
    case (r.command)
      CMD_READ: begin
        if (r.cluster < eff) o.cluster_result = link_table[r.cluster[15:0]];
        else o.error_code = ERR_RANGE;
      end
      CMD_WRITE: begin
        if (r.cluster == 0 || r.cluster >= eff) o.error_code = ERR_RANGE;
        else link_table[r.cluster[15:0]] = r.entry_value[LINK_W-1:0];
      end
      CMD_ALLOC: begin
        low = hint_model;
        while (low < eff && link_table[low[15:0]] != '0) low++;
        if (low < eff) begin
          hint_model = low[CNT_W-1:0];
          link_table[low[15:0]] = LINK_MASK;
          if (free_cache > 0) free_cache--;
          o.cluster_result = low;
        end else begin
          o.error_code = ERR_RANGE;
        end
      end
      CMD_FREE: begin
        cur = r.cluster;
        low = r.cluster;
        forever begin
          if (cur >= eff || cur == 0) begin
            o.error_code = ERR_RANGE;
            break;
          end
          nxt = link_table[cur[15:0]];
          link_table[cur[15:0]] = '0;
          if (cur < low) low = cur;
          len++;
          cur = nxt;
          if (link_ends(nxt)) break;
        end
        if (o.error_code == ERR_OK) begin
          if (hint_model > low) hint_model = low[CNT_W-1:0];
          sum = free_cache + len;
          free_cache = (sum > 32'h1FFFF) ? 17'h1FFFF : sum[CNT_W-1:0];
          o.count_result = len[CNT_W-1:0];
        end
      end
      CMD_WALK: begin
        cur = r.cluster;
        if (r.step_limit == 0) begin
          last = r.cluster;
          while (!link_ends(cur)) begin
            if (len >= eff) begin o.error_code = ERR_CYCLE; break; end
            if (cur >= eff) begin o.error_code = ERR_RANGE; break; end
            last = cur;
            cur = link_table[cur[15:0]];
            len++;
          end
          o.cluster_result = last;
        end else begin
          nxt = r.cluster;
          while (len < r.step_limit) begin
            if (len >= eff) begin o.error_code = ERR_CYCLE; break; end
            if (cur >= eff) begin o.error_code = ERR_RANGE; break; end
            nxt = link_table[cur[15:0]];
            len++;
            if (link_ends(nxt)) begin done = 1; break; end
            cur = nxt;
          end
          o.cluster_result = done ? cur : nxt;
        end
        o.count_result = len[CNT_W-1:0];
        if (o.error_code != ERR_OK) begin
          o.cluster_result = '0;
          o.count_result = '0;
        end
      end
      CMD_COUNT: begin
        if (free_cache == 0) begin
          zeros = 0;
          for (int i = 0; i < MAX_CLUSTERS; i++)
            if (link_table[i] == '0) zeros++;
          if (zeros > cluster_cfg) zeros = cluster_cfg;
          free_cache = zeros[CNT_W-1:0];
        end
        o.count_result = free_cache;
      end
      default: o.error_code = ERR_RANGE;
    endcase
    return o;
  endfunction

  // send one request, keeping valid high for a following request
  task automatic send_request(input logic [2:0] op, input logic [LINK_W-1:0] cl,
                              input logic [31:0] val, input logic [LINK_W-1:0] lim);
    req_t r;
    r.command = op;
    r.cluster = cl;
    r.entry_value = val;
    r.step_limit = lim;
    // an uncached count scans the whole table; only a few are allowed
    if (op == CMD_COUNT && free_cache == 0) begin
      if (full_scans_left == 0) r.command = CMD_READ;
      else full_scans_left--;
    end
    @(negedge clk);
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (req_stall);
    pending_rsp.push_back(table_apply(r));
    cmd_hits[r.command]++;
    requests_sent++;
  endtask

  task automatic sender_gap(input int cycles);
    @(negedge clk);
    req_valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // let everything drain before touching the register
  task automatic wait_drained();
    sender_gap(0);
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_cluster_count(input logic [CNT_W-1:0] v);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cluster_cfg = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [LINK_W-1:0] pick_cluster();
    int eff;
    int p;
    eff = usable_count();
    p = $urandom_range(99);
    if (p < 5) return $urandom;
    if (p < 20) return $urandom_range(2, eff - 1);
    return $urandom_range(0, eff + 1);
  endfunction

  function automatic logic [31:0] pick_entry();
    int eff;
    int p;
    eff = usable_count();
    p = $urandom_range(99);
    if (p < 45) return $urandom_range(2, (eff > 2) ? eff - 1 : 2);
    if (p < 60) return {4'($urandom), 28'($urandom_range(EOC_LOW, LINK_MASK))};
    if (p < 70) return '0;
    if (p < 85) return $urandom;
    return $urandom_range(eff, eff + 3);
  endfunction

  function automatic logic [LINK_W-1:0] pick_steps();
    int p;
    p = $urandom_range(99);
    if (p < 40) return '0;
    if (p < 80) return $urandom_range(1, 5);
    return $urandom;
  endfunction

  task automatic random_command();
    int p;
    logic [2:0] op;
    p = $urandom_range(99);
    if (p < 30) op = CMD_WRITE;
    else if (p < 45) op = CMD_ALLOC;
    else if (p < 57) op = CMD_FREE;
    else if (p < 77) op = CMD_WALK;
    else if (p < 90) op = CMD_READ;
    else if (p < 96) op = CMD_COUNT;
    else op = 3'($urandom_range(6, 7));
    send_request(op, pick_cluster(), pick_entry(), pick_steps());
  endtask

  // bursty sender: random run lengths, mostly with random gaps between them
  task automatic random_burst_phase(input logic [CNT_W-1:0] clusters, input int items);
    write_cluster_count(clusters);
    repeat (items) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        if ($urandom_range(3) != 0) sender_gap($urandom_range(1, 8));
      end
      burst_left--;
      random_command();
    end
  endtask

  task automatic test_table_extremes();
    send_request(CMD_READ,  0,            0,             0);
    send_request(CMD_READ,  65535,        0,             0);
    send_request(CMD_READ,  65536,        0,             0);
    send_request(CMD_READ,  LINK_MASK,    0,             0);
    send_request(CMD_WRITE, 0,            32'h1234,      0);
    send_request(CMD_WRITE, 65536,        32'h1234,      0);
    send_request(CMD_WRITE, 65535,        32'hFFFF_FFFF, 0);
    send_request(CMD_READ,  65535,        0,             0);
  endtask

  task automatic test_chain_walks();
    send_request(CMD_WRITE, 5, 32'hF000_0007, 0);
    send_request(CMD_WRITE, 7, 32'h0000_0009, 0);
    send_request(CMD_WRITE, 9, 32'h0FFF_FFF8, 0);
    send_request(CMD_WALK,  5,     0, 0);
    send_request(CMD_WALK,  5,     0, 1);
    send_request(CMD_WALK,  5,     0, 2);
    send_request(CMD_WALK,  5,     0, LINK_MASK);
    send_request(CMD_WALK,  65535, 0, 0);
    send_request(CMD_WALK,  3,     0, 0);
    send_request(CMD_WALK,  70000, 0, 0);
  endtask

  task automatic test_alloc_free_count();
    send_request(CMD_ALLOC, 0, 0, 0);
    send_request(CMD_ALLOC, 0, 0, 0);
    send_request(CMD_COUNT, 0, 0, 0);
    send_request(CMD_FREE,  5, 0, 0);
    send_request(CMD_FREE,  0, 0, 0);
    send_request(CMD_FREE,  65536, 0, 0);
    send_request(3'd6, LINK_MASK, 32'hFFFF_FFFF, LINK_MASK);
    send_request(3'd7, 0, 0, 0);
    send_request(CMD_COUNT, 0, 0, 0);
  endtask

  // loops: the walks must hit the cycle check, the free ends on a cleared entry
  task automatic test_chain_cycles();
    write_cluster_count(16);
    send_request(CMD_WRITE, 4, 6, 0);
    send_request(CMD_WRITE, 6, 4, 0);
    send_request(CMD_WALK,  4, 0, 0);
    send_request(CMD_WALK,  4, 0, LINK_MASK);
    send_request(CMD_FREE,  4, 0, 0);
  endtask

  task automatic test_smallest_table();
    write_cluster_count(2);
    send_request(CMD_ALLOC, 0, 0, 0);
    send_request(CMD_WRITE, 1, 32'h0000_0001, 0);
    send_request(CMD_WRITE, 2, 0, 0);
    send_request(CMD_READ,  1, 0, 0);
    send_request(CMD_WALK,  1, 0, 3);
    send_request(CMD_COUNT, 0, 0, 0);
  endtask

  // receiver stall pattern: one of three modes, drawn anew when its random run ends
  int stall_left = 0;
  int stall_mode = 0;
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(2);
      stall_left = $urandom_range(16, 96);
    end
    stall_left--;
    case (stall_mode)
      0: rsp_stall <= 1'b0;
      1: rsp_stall <= ($urandom_range(1) == 0);
      default: rsp_stall <= ($urandom_range(3) != 0);
    endcase
  end

  // response checker
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      responses_seen++;
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected response %h", rsp);
      end else begin
        want = pending_rsp.pop_front();
        if (rsp.cluster_result !== want.cluster_result ||
            rsp.count_result !== want.count_result ||
            rsp.error_code !== want.error_code) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: expected cl=%h cnt=%0d err=%0d, got cl=%h cnt=%0d err=%0d",
                     want.cluster_result, want.count_result, want.error_code,
                     rsp.cluster_result, rsp.count_result, rsp.error_code);
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("cluster_chain_table_engine_test NOT OK");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < MAX_CLUSTERS; i++) link_table[i] = '0;
    hint_model = 2;
    free_cache = '0;
    cluster_cfg = 17'd65536;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_table_extremes();
    test_chain_walks();
    test_alloc_free_count();
    test_chain_cycles();
    test_smallest_table();
    random_burst_phase(16, 150);
    random_burst_phase(2, 40);
    random_burst_phase(40, 150);
    random_burst_phase(300, 120);
    random_burst_phase(100, 150);
    random_burst_phase(17'd65536, 40);

    wait_drained();
    $display("%0d requests, %0d responses; reads %0d writes %0d allocs %0d frees %0d",
             requests_sent, responses_seen, cmd_hits[0], cmd_hits[1], cmd_hits[2],
             cmd_hits[3]);
    $display("walks %0d counts %0d unused codes %0d, cluster counts 2 to 65536",
             cmd_hits[4], cmd_hits[5], cmd_hits[6] + cmd_hits[7]);
    if (mismatches == 0)
      $display("cluster_chain_table_engine_test OK");
    else
      $display("cluster_chain_table_engine_test NOT OK");
    $finish;
  end

endmodule

`default_nettype wire
